// ----- rtl/core/blta_pkg.sv -----
package blta_pkg;

  localparam int DEF_MAX_BLOCK_SIZE = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int RAMP_MODE_W = 2;
  localparam int BLOCK_SIZE_W = 7;
  localparam int CHAR_W = 7;
  localparam int QUOT_BITS = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int LIN_MAX_W = 25;

  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = 2'd1;

  localparam logic [RAMP_MODE_W-1:0] MODE_DARK = 2'd0;
  localparam logic [RAMP_MODE_W-1:0] MODE_BRIGHT = 2'd1;
  localparam logic [RAMP_MODE_W-1:0] MODE_SHORT = 2'd2;

  localparam logic [RAMP_MODE_W-1:0] RESET_RAMP_MODE = MODE_DARK;
  localparam logic [BLOCK_SIZE_W-1:0] RESET_BLOCK_SIZE = 7'd8;

  localparam int DARK_LEN = 70;
  localparam int BRIGHT_LEN = 64;
  localparam int SHORT_LEN = 10;

  // backquote is stored as a stand-in letter and mapped back on lookup
  localparam logic [7:0] BACKQUOTE_STANDIN = "g";
  localparam logic [CHAR_W-1:0] BACKQUOTE = 7'h60;

  localparam logic [8*DARK_LEN-1:0] RAMP_DARK =
    "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^g'. ";
  localparam logic [8*BRIGHT_LEN-1:0] RAMP_BRIGHT =
    "g^\",:;Il!i~+_-?][}(1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao#MW&8%B@S";
  localparam logic [8*SHORT_LEN-1:0] RAMP_SHORT = " .:-=+*#%@";

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [QUOT_BITS-1:0] ramp_index;
  } out_word_t;

  typedef logic [LIN_MAX_W-1:0] lin_tab_t [256];

  function automatic int bs_cap(input int max_bs);
    return (max_bs < 127) ? max_bs : 127;
  endfunction

  function automatic int cnt_width(input int max_bs);
    int cap;
    cap = bs_cap(max_bs);
    return $clog2(2 * cap * cap + 1);
  endfunction

  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + Q30_HALF) >> 30;
  endfunction

  function automatic logic [63:0] pow5_30(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = mul30(r, r);
    r4 = mul30(r2, r2);
    return mul30(r4, r);
  endfunction

  function automatic logic [63:0] lin_calc(input int c, input int frac);
    logic [63:0] v;
    logic [63:0] u;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lin;
    if (c <= 10) begin
      return ((64'(10 * c) << frac) + 64'd16473) / 64'd32946;
    end
    v = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
    if (v > Q30_ONE) begin
      v = Q30_ONE;
    end
    u = mul30(v, v);
    lo = 64'd0;
    hi = Q30_ONE;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_30(mid) <= u) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    lin = mul30(u, lo);
    return (lin + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  function automatic lin_tab_t build_lin_tab(input int frac);
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = LIN_MAX_W'(lin_calc(c, frac));
    end
    return tab;
  endfunction

  function automatic logic [QUOT_BITS-1:0] ramp_last(input logic [RAMP_MODE_W-1:0] mode);
    logic [QUOT_BITS-1:0] last;
    unique case (mode)
      MODE_BRIGHT: last = QUOT_BITS'(BRIGHT_LEN - 1);
      MODE_SHORT:  last = QUOT_BITS'(SHORT_LEN - 1);
      default:     last = QUOT_BITS'(DARK_LEN - 1);
    endcase
    return last;
  endfunction

  function automatic logic [CHAR_W-1:0] ramp_char(input logic [RAMP_MODE_W-1:0] mode,
                                                  input logic [QUOT_BITS-1:0] idx);
    logic [7:0] ch;
    unique case (mode)
      MODE_BRIGHT: ch = RAMP_BRIGHT[8 * (BRIGHT_LEN - 1 - int'(idx)) +: 8];
      MODE_SHORT:  ch = RAMP_SHORT[8 * (SHORT_LEN - 1 - int'(idx)) +: 8];
      default:     ch = RAMP_DARK[8 * (DARK_LEN - 1 - int'(idx)) +: 8];
    endcase
    return (ch == BACKQUOTE_STANDIN) ? BACKQUOTE : ch[CHAR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/blta_front.sv -----
module blta_front #(
  parameter int MAX_BLOCK_SIZE = blta_pkg::DEF_MAX_BLOCK_SIZE,
  parameter int FRAC_BITS = blta_pkg::DEF_FRAC_BITS,
  localparam int CNT_W = blta_pkg::cnt_width(MAX_BLOCK_SIZE),
  localparam int SUM_W = FRAC_BITS + CNT_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [blta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [blta_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  blta_pkg::in_word_t                 in_data,
  input  logic                               job_pop,
  output logic                               job_push,
  output logic [SUM_W-1:0]                   job_sum,
  output logic [CNT_W-1:0]                   job_count,
  output logic [blta_pkg::RAMP_MODE_W-1:0]   job_mode
);
  import blta_pkg::*;

  localparam int LIN_W = FRAC_BITS + 1;
  localparam int S_W = FRAC_BITS + 14;
  localparam int T_W = FRAC_BITS + 10;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int TOT_W = 2 * BLOCK_SIZE_W + 1;
  localparam int JOBS_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STAGES = 5;
  localparam lin_tab_t LIN_TAB = build_lin_tab(FRAC_BITS);
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << T_W) / 64'd625);
  localparam logic [BLOCK_SIZE_W-1:0] BS_LIMIT = BLOCK_SIZE_W'(bs_cap(MAX_BLOCK_SIZE));

  typedef struct packed {
    logic                   last;
    logic [CNT_W-1:0]       count;
    logic [RAMP_MODE_W-1:0] mode;
  } tag_t;

  logic [RAMP_MODE_W-1:0]  ramp_mode;
  logic [BLOCK_SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]        pixel_count;
  logic [JOBS_W-1:0]       jobs;
  logic [SUM_W-1:0]        luma_sum;
  logic [STAGES-1:0]       valid;
  tag_t                    tag [STAGES];

  logic [7:0]       red0, green0, blue0;
  logic [LIN_W-1:0] lin_r, lin_g, lin_b;
  logic [S_W-1:0]   wsum;
  logic [T_W-1:0]   tq, tq_next;
  logic [Q_W-1:0]   q_est;
  logic [Q_W-1:0]   pix;

  logic [BLOCK_SIZE_W-1:0] bs;
  logic [TOT_W-1:0]        total;
  logic [TOT_W-1:0]        n_ext;
  logic                    will_close;
  logic                    accept;
  logic [SUM_W-1:0]        sum_next;
  logic [T_W+Q_W-1:0]      prod;
  logic [T_W-1:0]          rem;

  always_comb begin
    bs = block_size;
    if (block_size == '0) begin
      bs = BLOCK_SIZE_W'(1);
    end else if (block_size > BS_LIMIT) begin
      bs = BS_LIMIT;
    end
  end

  assign total = TOT_W'(2) * TOT_W'(bs) * TOT_W'(bs);
  assign n_ext = TOT_W'(pixel_count) + TOT_W'(1);
  assign will_close = (n_ext >= total);
  assign in_stall = will_close && (jobs >= JOBS_W'(QUEUE_DEPTH));
  assign accept = in_valid && !in_stall;

  assign tq_next = wsum[S_W-1:4];
  assign prod = (T_W + Q_W)'(tq_next) * (T_W + Q_W)'(RECIP);
  assign rem = tq - T_W'(q_est) * T_W'(625);
  assign sum_next = luma_sum + SUM_W'(pix);

  assign job_push = valid[STAGES-1] && tag[STAGES-1].last;
  assign job_sum = sum_next;
  assign job_count = tag[STAGES-1].count;
  assign job_mode = tag[STAGES-1].mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_mode <= RESET_RAMP_MODE;
      block_size <= RESET_BLOCK_SIZE;
      pixel_count <= '0;
      jobs <= '0;
      luma_sum <= '0;
      valid <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_RAMP_MODE) begin
        ramp_mode <= cfg_data[RAMP_MODE_W-1:0];
      end
      if (cfg_we && cfg_index == REG_BLOCK_SIZE) begin
        block_size <= cfg_data[BLOCK_SIZE_W-1:0];
      end
      valid <= {valid[STAGES-2:0], accept};
      if (accept) begin
        pixel_count <= will_close ? '0 : CNT_W'(n_ext);
      end
      jobs <= jobs + JOBS_W'(accept && will_close) - JOBS_W'(job_pop);
      if (valid[STAGES-1]) begin
        luma_sum <= tag[STAGES-1].last ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= '{last: will_close, count: CNT_W'(n_ext), mode: ramp_mode};
    for (int i = 1; i < STAGES; i++) begin
      tag[i] <= tag[i-1];
    end
    red0 <= in_data.red;
    green0 <= in_data.green;
    blue0 <= in_data.blue;
    lin_r <= LIN_TAB[red0][LIN_W-1:0];
    lin_g <= LIN_TAB[green0][LIN_W-1:0];
    lin_b <= LIN_TAB[blue0][LIN_W-1:0];
    wsum <= S_W'(lin_r) * S_W'(2126) + S_W'(lin_g) * S_W'(7152)
          + S_W'(lin_b) * S_W'(722) + S_W'(5000);
    tq <= tq_next;
    q_est <= prod[T_W +: Q_W];
    pix <= q_est + Q_W'(rem >= T_W'(625));
  end

endmodule

// ----- rtl/core/blta_fifo.sv -----
module blta_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import blta_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/blta_back.sv -----
module blta_back #(
  parameter int MAX_BLOCK_SIZE = blta_pkg::DEF_MAX_BLOCK_SIZE,
  parameter int FRAC_BITS = blta_pkg::DEF_FRAC_BITS,
  localparam int CNT_W = blta_pkg::cnt_width(MAX_BLOCK_SIZE),
  localparam int SUM_W = FRAC_BITS + CNT_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               job_valid,
  input  logic [SUM_W-1:0]                   job_sum,
  input  logic [CNT_W-1:0]                   job_count,
  input  logic [blta_pkg::RAMP_MODE_W-1:0]   job_mode,
  output logic                               job_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output blta_pkg::out_word_t                out_data
);
  import blta_pkg::*;

  localparam int NUM_W = SUM_W + 8;
  localparam int STEP_W = $clog2(QUOT_BITS);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  logic [STEP_W-1:0]      step;
  logic [NUM_W-1:0]       num;
  logic [NUM_W-1:0]       den;
  logic [QUOT_BITS-1:0]   quo;
  logic [RAMP_MODE_W-1:0] mode;

  logic [QUOT_BITS:0]     scale;
  logic [NUM_W-1:0]       num_init;
  logic [NUM_W-1:0]       den_init;
  logic                   fits;
  logic [QUOT_BITS-1:0]   last_idx;
  logic [QUOT_BITS-1:0]   idx;
  logic                   release_out;

  assign job_pop = (state == ST_IDLE) && job_valid;
  assign scale = {ramp_last(job_mode), 1'b0};
  assign num_init = NUM_W'(job_sum) * NUM_W'(scale) + (NUM_W'(job_count) << FRAC_BITS);
  assign den_init = NUM_W'(job_count) << (FRAC_BITS + QUOT_BITS);
  assign fits = (num >= den);
  assign last_idx = ramp_last(mode);
  assign idx = (quo > last_idx) ? last_idx : quo;
  assign release_out = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (release_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (release_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      num <= num_init;
      den <= den_init;
      quo <= '0;
      step <= STEP_W'(QUOT_BITS - 1);
      mode <= job_mode;
    end else if (state == ST_DIV) begin
      if (fits) begin
        num <= num - den;
      end
      quo <= {quo[QUOT_BITS-2:0], fits};
      den <= den >> 1;
      step <= step - STEP_W'(1);
    end
    if (release_out) begin
      out_data.char_code <= ramp_char(mode, idx);
      out_data.ramp_index <= idx;
    end
  end

endmodule

// ----- rtl/core/block_luminance_to_ascii_core.sv -----
// Luminance to character cell converter.
// Input channel (in_valid / in_stall / in_data): one sRGB pixel per word, the
// pixels of one character cell in cell order; a cell holds 2 * block_size *
// block_size pixels. Pixels are taken one per cycle while in_stall is low.
// Output channel (out_valid / out_stall / out_data): one word per cell, the
// ramp character and its index, produced from the cell's mean luminance.
// Configuration: cfg_we with cfg_index 0 sets ramp_mode, 1 sets block_size;
// write only while no cell is in progress.
// Each pixel passes a five-stage lookup and weighting pipeline; the cell mean
// is formed by a restoring divider that handles one cell at a time, so short
// cells run at the divider's pace.
// A two-entry queue sits between the accumulator and the divider. With the
// receiver stalling, the result register holds, the queue fills, and then the
// input stalls only on a cell's last pixel.
// Reset clears the accumulator and count, and restores ramp_mode 0 and
// block_size 8.
module block_luminance_to_ascii_core #(
  parameter int MAX_BLOCK_SIZE = blta_pkg::DEF_MAX_BLOCK_SIZE,
  parameter int FRAC_BITS = blta_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [blta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [blta_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  blta_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output blta_pkg::out_word_t                out_data
);
  import blta_pkg::*;

  localparam int CNT_W = cnt_width(MAX_BLOCK_SIZE);
  localparam int SUM_W = FRAC_BITS + CNT_W;
  localparam int JOB_W = SUM_W + CNT_W + RAMP_MODE_W;

  logic                   job_push;
  logic [SUM_W-1:0]       push_sum;
  logic [CNT_W-1:0]       push_count;
  logic [RAMP_MODE_W-1:0] push_mode;
  logic                   job_pop;
  logic                   head_valid;
  logic [JOB_W-1:0]       head_data;

  blta_front #(
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .job_pop(job_pop),
    .job_push(job_push),
    .job_sum(push_sum),
    .job_count(push_count),
    .job_mode(push_mode)
  );

  blta_fifo #(
    .W(JOB_W)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .push_data({push_sum, push_count, push_mode}),
    .pop(job_pop),
    .head_valid(head_valid),
    .head_data(head_data)
  );

  blta_back #(
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(head_valid),
    .job_sum(head_data[JOB_W-1 -: SUM_W]),
    .job_count(head_data[RAMP_MODE_W +: CNT_W]),
    .job_mode(head_data[RAMP_MODE_W-1:0]),
    .job_pop(job_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> head_valid)
    else $error("divider took a job from an empty queue");

  a_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> !job_pop)
    else $error("divider took two jobs in a row");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.ramp_index <= QUOT_BITS'(DARK_LEN - 1))
                  && (out_data.char_code >= 7'd32) && (out_data.char_code <= 7'd126))
    else $error("result word out of range");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import blta_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int MAX_BS = DEF_MAX_BLOCK_SIZE;
  localparam bit [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam bit [63:0] HALF_Q30 = 64'd1 << 29;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam logic [RAMP_MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum {TONE_NOISE, TONE_FLAT, TONE_EXTREME, TONE_DARK} tone_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;

  block_luminance_to_ascii_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // stand-in G marks the backquote, patched at start
  string dark_ramp =
    "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^G'. ";
  string bright_ramp =
    "G^\",:;Il!i~+_-?][}(1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao#MW&8%B@S";
  string short_ramp = " .:-=+*#%@";

  bit [31:0] linear_lut [256];
  in_word_t pixel_q [$];
  out_word_t glyph_q [$];
  out_word_t expected_w;

  logic [RAMP_MODE_W-1:0] ramp_sel;
  logic [BLOCK_SIZE_W-1:0] cell_width;
  bit [63:0] luma_acc;
  int unsigned cell_count;

  int errors = 0;
  int cycles = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_gap = 0;
  int in_gap_max = 0;
  int out_hold = 0;
  int out_gap_max = 0;
  int gap_choices [3] = '{0, 3, 12};

  function automatic bit [63:0] q30_mul(input bit [63:0] a, input bit [63:0] b);
    return (a * b + HALF_Q30) >> 30;
  endfunction

  // sRGB decode to linear light, unsigned with FRAC fraction bits
  function automatic bit [31:0] srgb_decode(input int c);
    bit [63:0] v, sq, lo, hi, mid, p2, p4;
    if (c <= 10) begin
      return 32'(((64'(10 * c) << FRAC) + 64'd16473) / 64'd32946);
    end
    v = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
    if (v > UNIT_Q30) begin
      v = UNIT_Q30;
    end
    sq = q30_mul(v, v);
    lo = 64'd0;
    hi = UNIT_Q30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      p2 = q30_mul(mid, mid);
      p4 = q30_mul(p2, p2);
      if (q30_mul(p4, mid) <= sq) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return 32'((q30_mul(sq, lo) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  task automatic absorb_pixel(input in_word_t px);
    int unsigned width_eff, cell_total, n, len;
    bit [63:0] luma, num, den, idx;
    string ramp;
    out_word_t w;
    width_eff = (cell_width == 0) ? 1 : (cell_width > MAX_BS) ? MAX_BS : cell_width;
    cell_total = 2 * width_eff * width_eff;
    luma = (64'd2126 * linear_lut[px.red] + 64'd7152 * linear_lut[px.green]
            + 64'd722 * linear_lut[px.blue] + 64'd5000) / 64'd10000;
    luma_acc += luma;
    n = cell_count + 1;
    if (n < cell_total) begin
      cell_count = n;
    end else begin
      case (ramp_sel)
        MODE_BRIGHT: ramp = bright_ramp;
        MODE_SHORT: ramp = short_ramp;
        default: ramp = dark_ramp;
      endcase
      len = ramp.len();
      num = 64'd2 * luma_acc * 64'(len - 1) + (64'(n) << FRAC);
      den = 64'(2 * n) << FRAC;
      idx = num / den;
      if (idx > 64'(len - 1)) begin
        idx = 64'(len - 1);
      end
      w.char_code = 7'(ramp[int'(idx)]);
      w.ramp_index = idx[QUOT_BITS-1:0];
      glyph_q.push_back(w);
      luma_acc = 64'd0;
      cell_count = 0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor and prediction
  always @(posedge clk) begin
    cycles++;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst) begin
      ramp_sel = RESET_RAMP_MODE;
      cell_width = RESET_BLOCK_SIZE;
      luma_acc = 64'd0;
      cell_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (glyph_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, char_code %0d ramp_index %0d", $time,
                   out_data.char_code, out_data.ramp_index);
        end else begin
          expected_w = glyph_q.pop_front();
          if (out_data.char_code !== expected_w.char_code) begin
            errors++;
            $display("%0t: char_code expected %0d got %0d", $time,
                     expected_w.char_code, out_data.char_code);
          end
          if (out_data.ramp_index !== expected_w.ramp_index) begin
            errors++;
            $display("%0t: ramp_index expected %0d got %0d", $time,
                     expected_w.ramp_index, out_data.ramp_index);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_RAMP_MODE) begin
          ramp_sel = cfg_data[RAMP_MODE_W-1:0];
        end else if (cfg_index == REG_BLOCK_SIZE) begin
          cell_width = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        absorb_pixel(in_data);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (out_taken) begin
      out_hold = $urandom_range(0, out_gap_max);
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic settle();
    while (!(pixel_q.size() == 0 && !in_valid && glyph_q.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_q.push_back({r, g, b});
  endtask

  task automatic add_cell(input int len);
    tone_e tone;
    in_word_t base, px;
    tone = tone_e'($urandom_range(0, 3));
    base = 24'($urandom);
    for (int k = 0; k < len; k++) begin
      case (tone)
        TONE_NOISE: px = 24'($urandom);
        TONE_FLAT: px = base;
        TONE_EXTREME: begin
          px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
          px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
          px.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        default: px = 24'($urandom) & 24'h0f0f0f;
      endcase
      pixel_q.push_back(px);
    end
  endtask

  initial begin
    int random_left, width, eff, cells, cell_len, pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    dark_ramp.putc(66, 8'h60);
    bright_ramp.putc(0, 8'h60);
    for (int c = 0; c < 256; c++) begin
      linear_lut[c] = srgb_decode(c);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one cell at the reset settings
    in_gap_max = 3;
    out_gap_max = 3;
    add_cell(2 * RESET_BLOCK_SIZE * RESET_BLOCK_SIZE);
    settle();

    // directed: extremes, every ramp, unused mode and index, zero width
    write_reg(REG_BLOCK_SIZE, 7'd1);
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'hff, 8'hff, 8'hff);
    add_pixel(8'hff, 8'hff, 8'hff);
    add_pixel(8'd10, 8'd10, 8'd10);
    add_pixel(8'd11, 8'd11, 8'd11);
    add_pixel(8'hff, 8'h00, 8'h00);
    add_pixel(8'h00, 8'hff, 8'h00);
    settle();
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_BRIGHT));
    add_pixel(8'hff, 8'hff, 8'hff);
    add_pixel(8'h00, 8'h00, 8'hff);
    settle();
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_SHORT));
    add_pixel(8'hff, 8'hff, 8'hff);
    add_pixel(8'hff, 8'hff, 8'hff);
    settle();
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_SPARE));
    write_reg(REG_UNUSED_LO, 7'h7f);
    write_reg(REG_UNUSED_HI, 7'h00);
    add_pixel(8'h55, 8'haa, 8'h55);
    add_pixel(8'haa, 8'h55, 8'haa);
    settle();
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_DARK));
    write_reg(REG_BLOCK_SIZE, 7'd0);
    add_pixel(8'h01, 8'h02, 8'h04);
    add_pixel(8'hfe, 8'hfd, 8'hfb);
    settle();

    // shrink the cell while pixels are held: closes on the next pixel
    write_reg(REG_BLOCK_SIZE, 7'd2);
    add_cell(5);
    settle();
    write_reg(REG_BLOCK_SIZE, 7'd1);
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_BRIGHT));
    add_pixel(8'h80, 8'h40, 8'h20);
    settle();
    add_pixel(8'h08, 8'h10, 8'h20);
    settle();
    write_reg(REG_BLOCK_SIZE, 7'd2);
    add_cell(7);
    settle();

    // widest setting saturates; shrink to close the long cell early
    in_gap_max = 0;
    out_gap_max = 12;
    write_reg(REG_BLOCK_SIZE, 7'd127);
    add_cell(40);
    settle();
    write_reg(REG_BLOCK_SIZE, 7'd1);
    write_reg(REG_RAMP_MODE, CFG_DATA_W'(MODE_SHORT));
    add_pixel(8'hff, 8'hff, 8'hff);

    width = MAX_BS;
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      settle();
      in_gap_max = gap_choices[$urandom_range(0, 2)];
      out_gap_max = gap_choices[$urandom_range(0, 2)];
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_RAMP_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      end
      if (width > 10 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          width = $urandom_range(1, 3);
        end else if (pick < 18) begin
          width = $urandom_range(4, 6);
        end else if (pick == 18) begin
          width = 0;
        end else begin
          width = $urandom_range(7, 10);
        end
        write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(width));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  CFG_DATA_W'($urandom));
      end
      eff = (width == 0) ? 1 : width;
      cell_len = 2 * eff * eff;
      cells = (cell_len > 50) ? 1 : $urandom_range(1, 5);
      repeat (cells) add_cell(cell_len);
      random_left -= cells * cell_len;
      if (cell_len > 1 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(1, cell_len - 1);
        add_cell(pick);
        random_left -= pick;
      end
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/blta_pkg.sv
rtl/core/blta_front.sv
rtl/core/blta_fifo.sv
rtl/core/blta_back.sv
rtl/core/block_luminance_to_ascii_core.sv
test/testbench.sv
